@@ src/esc_pkg.sv @@
// ----------------------------------------------------------------------------
// esc_pkg: shared types, constants and microcode for the compensation core
// Operand and opcode encodings, coefficient selection, and the step programs.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    localparam logic [15:0] MAX_BATCH_SAMPLES = 16'd65535;
    localparam logic [15:0] CNT_SAT           = 16'hFFFF;
    localparam logic [31:0] HUM_CLAMP_MAX     = 32'd419430400;
    // ceil(2^24 / 102); exact floor division for dividends up to 102400
    localparam logic [63:0] HUM_RECIP_102     = 64'd164483;

    // action / quantity codes
    localparam logic [1:0] ACT_TEMP  = 2'd0;
    localparam logic [1:0] ACT_PRESS = 2'd1;
    localparam logic [1:0] ACT_HUM   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_TEMP     = 3'd0;
    localparam logic [2:0] REG_PRESS_LO = 3'd1;
    localparam logic [2:0] REG_PRESS_HI = 3'd2;
    localparam logic [2:0] REG_PRESS_P9 = 3'd3;
    localparam logic [2:0] REG_HUM      = 3'd4;

    // program entry points
    localparam logic [6:0] PC_TEMP  = 7'd0;
    localparam logic [6:0] PC_PRESS = 7'd16;
    localparam logic [6:0] PC_AVG   = 7'd49;
    localparam logic [6:0] PC_HUM   = 7'd52;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_SRA, OP_SHL, OP_SHR, OP_SDIV, OP_UDIV, OP_CLAMP
    } alu_op_t;

    typedef enum logic [3:0] {
        SRC_X, SRC_Y, SRC_Z, SRC_W, SRC_K, SRC_C, SRC_FT, SRC_ADC, SRC_HADC,
        SRC_SUM, SRC_CNT
    } src_t;

    typedef enum logic [2:0] {
        DST_X, DST_Y, DST_Z, DST_W, DST_FT, DST_SUM, DST_OUT
    } dst_t;

    typedef enum logic [4:0] {
        C_T1, C_T2, C_T3,
        C_P1, C_P2, C_P3, C_P4, C_P5, C_P6, C_P7, C_P8, C_P9,
        C_H1, C_H2, C_H3, C_H4, C_H5, C_H6
    } coef_t;

    // what follows a step: next step, zero test, batch decision, result, average
    typedef enum logic [2:0] {
        NX_STEP, NX_ZCHK, NX_BATCH, NX_OUT, NX_AVG
    } nxt_t;

    typedef struct packed {
        alu_op_t     op;
        src_t        a;
        src_t        b;
        coef_t       c;
        logic [63:0] k;
        logic [5:0]  sh;
        dst_t        dst;
        logic        w32;
        nxt_t        nx;
    } uop_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        start;
        logic        sgn;
        logic [63:0] a;
        logic [63:0] b;
    } div_req_t;

    function automatic uop_t mk(input alu_op_t op, input src_t a, input src_t b,
                                input coef_t c, input logic [63:0] k,
                                input logic [5:0] sh, input dst_t dst,
                                input logic w32, input nxt_t nx);
        uop_t u;
        u.op  = op;
        u.a   = a;
        u.b   = b;
        u.c   = c;
        u.k   = k;
        u.sh  = sh;
        u.dst = dst;
        u.w32 = w32;
        u.nx  = nx;
        return u;
    endfunction

    function automatic uop_t ucode(input logic [6:0] pc);
        uop_t u;
        case (pc)
            // temperature
            7'd0:  u = mk(OP_SHR, SRC_ADC, SRC_K, C_T1, 64'd0, 6'd3, DST_X, 1'b0, NX_STEP);
            7'd1:  u = mk(OP_SHL, SRC_C, SRC_K, C_T1, 64'd0, 6'd1, DST_Y, 1'b0, NX_STEP);
            7'd2:  u = mk(OP_SUB, SRC_X, SRC_Y, C_T1, 64'd0, 6'd0, DST_X, 1'b0, NX_STEP);
            7'd3:  u = mk(OP_MUL, SRC_X, SRC_C, C_T2, 64'd0, 6'd0, DST_X, 1'b0, NX_STEP);
            7'd4:  u = mk(OP_SRA, SRC_X, SRC_K, C_T1, 64'd0, 6'd11, DST_X, 1'b0, NX_STEP);
            7'd5:  u = mk(OP_SHR, SRC_ADC, SRC_K, C_T1, 64'd0, 6'd4, DST_Y, 1'b0, NX_STEP);
            7'd6:  u = mk(OP_SUB, SRC_Y, SRC_C, C_T1, 64'd0, 6'd0, DST_Y, 1'b0, NX_STEP);
            7'd7:  u = mk(OP_MUL, SRC_Y, SRC_Y, C_T1, 64'd0, 6'd0, DST_Y, 1'b0, NX_STEP);
            7'd8:  u = mk(OP_SRA, SRC_Y, SRC_K, C_T1, 64'd0, 6'd12, DST_Y, 1'b0, NX_STEP);
            7'd9:  u = mk(OP_MUL, SRC_Y, SRC_C, C_T3, 64'd0, 6'd0, DST_Y, 1'b0, NX_STEP);
            7'd10: u = mk(OP_SRA, SRC_Y, SRC_K, C_T1, 64'd0, 6'd14, DST_Y, 1'b0, NX_STEP);
            7'd11: u = mk(OP_ADD, SRC_X, SRC_Y, C_T1, 64'd0, 6'd0, DST_FT, 1'b0, NX_STEP);
            7'd12: u = mk(OP_MUL, SRC_FT, SRC_K, C_T1, 64'd5, 6'd0, DST_X, 1'b0, NX_STEP);
            7'd13: u = mk(OP_ADD, SRC_X, SRC_K, C_T1, 64'd128, 6'd0, DST_X, 1'b0, NX_STEP);
            7'd14: u = mk(OP_SRA, SRC_X, SRC_K, C_T1, 64'd0, 6'd8, DST_OUT, 1'b0, NX_OUT);
            // pressure
            7'd16: u = mk(OP_SUB, SRC_FT, SRC_K, C_P1, 64'd128000, 6'd0, DST_X, 1'b0,
                          NX_STEP);
            7'd17: u = mk(OP_MUL, SRC_X, SRC_X, C_P1, 64'd0, 6'd0, DST_Y, 1'b0, NX_STEP);
            7'd18: u = mk(OP_MUL, SRC_Y, SRC_C, C_P6, 64'd0, 6'd0, DST_Z, 1'b0, NX_STEP);
            7'd19: u = mk(OP_MUL, SRC_X, SRC_C, C_P5, 64'd0, 6'd0, DST_W, 1'b0, NX_STEP);
            7'd20: u = mk(OP_SHL, SRC_W, SRC_K, C_P1, 64'd0, 6'd17, DST_W, 1'b0, NX_STEP);
            7'd21: u = mk(OP_ADD, SRC_Z, SRC_W, C_P1, 64'd0, 6'd0, DST_Z, 1'b0, NX_STEP);
            7'd22: u = mk(OP_SHL, SRC_C, SRC_K, C_P4, 64'd0, 6'd35, DST_W, 1'b0, NX_STEP);
            7'd23: u = mk(OP_ADD, SRC_Z, SRC_W, C_P1, 64'd0, 6'd0, DST_Z, 1'b0, NX_STEP);
            7'd24: u = mk(OP_MUL, SRC_Y, SRC_C, C_P3, 64'd0, 6'd0, DST_Y, 1'b0, NX_STEP);
            7'd25: u = mk(OP_SRA, SRC_Y, SRC_K, C_P1, 64'd0, 6'd8, DST_Y, 1'b0, NX_STEP);
            7'd26: u = mk(OP_MUL, SRC_X, SRC_C, C_P2, 64'd0, 6'd0, DST_W, 1'b0, NX_STEP);
            7'd27: u = mk(OP_SHL, SRC_W, SRC_K, C_P1, 64'd0, 6'd12, DST_W, 1'b0, NX_STEP);
            7'd28: u = mk(OP_ADD, SRC_Y, SRC_W, C_P1, 64'd0, 6'd0, DST_X, 1'b0, NX_STEP);
            7'd29: u = mk(OP_ADD, SRC_X, SRC_K, C_P1, 64'h0000_8000_0000_0000, 6'd0,
                          DST_X, 1'b0, NX_STEP);
            7'd30: u = mk(OP_MUL, SRC_X, SRC_C, C_P1, 64'd0, 6'd0, DST_X, 1'b0, NX_STEP);
            7'd31: u = mk(OP_SRA, SRC_X, SRC_K, C_P1, 64'd0, 6'd33, DST_X, 1'b0, NX_ZCHK);
            7'd32: u = mk(OP_SUB, SRC_K, SRC_ADC, C_P1, 64'd1048576, 6'd0, DST_Y, 1'b0,
                          NX_STEP);
            7'd33: u = mk(OP_SHL, SRC_Y, SRC_K, C_P1, 64'd0, 6'd31, DST_Y, 1'b0, NX_STEP);
            7'd34: u = mk(OP_SUB, SRC_Y, SRC_Z, C_P1, 64'd0, 6'd0, DST_Y, 1'b0, NX_STEP);
            7'd35: u = mk(OP_MUL, SRC_Y, SRC_K, C_P1, 64'd3125, 6'd0, DST_Y, 1'b0, NX_STEP);
            7'd36: u = mk(OP_SDIV, SRC_Y, SRC_X, C_P1, 64'd0, 6'd0, DST_Y, 1'b0, NX_STEP);
            7'd37: u = mk(OP_SRA, SRC_Y, SRC_K, C_P1, 64'd0, 6'd13, DST_Z, 1'b0, NX_STEP);
            7'd38: u = mk(OP_MUL, SRC_Z, SRC_C, C_P9, 64'd0, 6'd0, DST_W, 1'b0, NX_STEP);
            7'd39: u = mk(OP_MUL, SRC_W, SRC_Z, C_P1, 64'd0, 6'd0, DST_W, 1'b0, NX_STEP);
            7'd40: u = mk(OP_SRA, SRC_W, SRC_K, C_P1, 64'd0, 6'd25, DST_W, 1'b0, NX_STEP);
            7'd41: u = mk(OP_MUL, SRC_Y, SRC_C, C_P8, 64'd0, 6'd0, DST_Z, 1'b0, NX_STEP);
            7'd42: u = mk(OP_SRA, SRC_Z, SRC_K, C_P1, 64'd0, 6'd19, DST_Z, 1'b0, NX_STEP);
            7'd43: u = mk(OP_ADD, SRC_Y, SRC_W, C_P1, 64'd0, 6'd0, DST_Y, 1'b0, NX_STEP);
            7'd44: u = mk(OP_ADD, SRC_Y, SRC_Z, C_P1, 64'd0, 6'd0, DST_Y, 1'b0, NX_STEP);
            7'd45: u = mk(OP_SRA, SRC_Y, SRC_K, C_P1, 64'd0, 6'd8, DST_Y, 1'b0, NX_STEP);
            7'd46: u = mk(OP_SHL, SRC_C, SRC_K, C_P7, 64'd0, 6'd4, DST_W, 1'b0, NX_STEP);
            7'd47: u = mk(OP_ADD, SRC_Y, SRC_W, C_P1, 64'd0, 6'd0, DST_Y, 1'b0, NX_STEP);
            7'd48: u = mk(OP_ADD, SRC_SUM, SRC_Y, C_P1, 64'd0, 6'd0, DST_SUM, 1'b0,
                          NX_BATCH);
            // batch average
            7'd49: u = mk(OP_MUL, SRC_CNT, SRC_K, C_P1, 64'd26, 6'd0, DST_X, 1'b0, NX_STEP);
            7'd50: u = mk(OP_UDIV, SRC_SUM, SRC_X, C_P1, 64'd0, 6'd0, DST_OUT, 1'b0,
                          NX_AVG);
            // humidity, 32-bit wrapping
            7'd52: u = mk(OP_SUB, SRC_FT, SRC_K, C_H1, 64'd76800, 6'd0, DST_X, 1'b1,
                          NX_STEP);
            7'd53: u = mk(OP_SHL, SRC_HADC, SRC_K, C_H1, 64'd0, 6'd14, DST_Y, 1'b1, NX_STEP);
            7'd54: u = mk(OP_SHL, SRC_C, SRC_K, C_H4, 64'd0, 6'd20, DST_Z, 1'b1, NX_STEP);
            7'd55: u = mk(OP_SUB, SRC_Y, SRC_Z, C_H1, 64'd0, 6'd0, DST_Y, 1'b1, NX_STEP);
            7'd56: u = mk(OP_MUL, SRC_C, SRC_X, C_H5, 64'd0, 6'd0, DST_Z, 1'b1, NX_STEP);
            7'd57: u = mk(OP_SUB, SRC_Y, SRC_Z, C_H1, 64'd0, 6'd0, DST_Y, 1'b1, NX_STEP);
            7'd58: u = mk(OP_ADD, SRC_Y, SRC_K, C_H1, 64'd16384, 6'd0, DST_Y, 1'b1, NX_STEP);
            7'd59: u = mk(OP_SRA, SRC_Y, SRC_K, C_H1, 64'd0, 6'd15, DST_Y, 1'b1, NX_STEP);
            7'd60: u = mk(OP_MUL, SRC_X, SRC_C, C_H6, 64'd0, 6'd0, DST_Z, 1'b1, NX_STEP);
            7'd61: u = mk(OP_SRA, SRC_Z, SRC_K, C_H1, 64'd0, 6'd10, DST_Z, 1'b1, NX_STEP);
            7'd62: u = mk(OP_MUL, SRC_X, SRC_C, C_H3, 64'd0, 6'd0, DST_W, 1'b1, NX_STEP);
            7'd63: u = mk(OP_SRA, SRC_W, SRC_K, C_H1, 64'd0, 6'd11, DST_W, 1'b1, NX_STEP);
            7'd64: u = mk(OP_ADD, SRC_W, SRC_K, C_H1, 64'd32768, 6'd0, DST_W, 1'b1, NX_STEP);
            7'd65: u = mk(OP_MUL, SRC_Z, SRC_W, C_H1, 64'd0, 6'd0, DST_Z, 1'b1, NX_STEP);
            7'd66: u = mk(OP_SRA, SRC_Z, SRC_K, C_H1, 64'd0, 6'd10, DST_Z, 1'b1, NX_STEP);
            7'd67: u = mk(OP_ADD, SRC_Z, SRC_K, C_H1, 64'd2097152, 6'd0, DST_Z, 1'b1,
                          NX_STEP);
            7'd68: u = mk(OP_MUL, SRC_Z, SRC_C, C_H2, 64'd0, 6'd0, DST_Z, 1'b1, NX_STEP);
            7'd69: u = mk(OP_ADD, SRC_Z, SRC_K, C_H1, 64'd8192, 6'd0, DST_Z, 1'b1, NX_STEP);
            7'd70: u = mk(OP_SRA, SRC_Z, SRC_K, C_H1, 64'd0, 6'd14, DST_Z, 1'b1, NX_STEP);
            7'd71: u = mk(OP_MUL, SRC_Y, SRC_Z, C_H1, 64'd0, 6'd0, DST_X, 1'b1, NX_STEP);
            7'd72: u = mk(OP_SRA, SRC_X, SRC_K, C_H1, 64'd0, 6'd15, DST_Y, 1'b1, NX_STEP);
            7'd73: u = mk(OP_MUL, SRC_Y, SRC_Y, C_H1, 64'd0, 6'd0, DST_Y, 1'b1, NX_STEP);
            7'd74: u = mk(OP_SRA, SRC_Y, SRC_K, C_H1, 64'd0, 6'd7, DST_Y, 1'b1, NX_STEP);
            7'd75: u = mk(OP_MUL, SRC_Y, SRC_C, C_H1, 64'd0, 6'd0, DST_Y, 1'b1, NX_STEP);
            7'd76: u = mk(OP_SRA, SRC_Y, SRC_K, C_H1, 64'd0, 6'd4, DST_Y, 1'b1, NX_STEP);
            7'd77: u = mk(OP_SUB, SRC_X, SRC_Y, C_H1, 64'd0, 6'd0, DST_X, 1'b1, NX_STEP);
            7'd78: u = mk(OP_CLAMP, SRC_X, SRC_K, C_H1, 64'd0, 6'd0, DST_X, 1'b1, NX_STEP);
            7'd79: u = mk(OP_SHR, SRC_X, SRC_K, C_H1, 64'd0, 6'd12, DST_X, 1'b1, NX_STEP);
            // divide by 102 as a reciprocal multiply; the product needs full width
            7'd80: u = mk(OP_MUL, SRC_X, SRC_K, C_H1, HUM_RECIP_102, 6'd0, DST_X, 1'b0,
                          NX_STEP);
            7'd81: u = mk(OP_SHR, SRC_X, SRC_K, C_H1, 64'd0, 6'd24, DST_OUT, 1'b0,
                          NX_OUT);
            default: u = mk(OP_ADD, SRC_K, SRC_K, C_T1, 64'd0, 6'd0, DST_OUT, 1'b0,
                            NX_OUT);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

@@ src/esc_if.sv @@
// ----------------------------------------------------------------------------
// esc_if: channel interfaces of the compensation core
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface esc_sample_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [19:0] raw_reading;
    logic        batch_end;
    modport source (output valid, action, raw_reading, batch_end, input ready);
    modport sink   (input valid, action, raw_reading, batch_end, output ready);
endinterface

interface esc_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         quantity;
    logic signed [32:0] reading;
    logic               zero_divisor;
    modport source (output valid, quantity, reading, zero_divisor, input ready);
    modport sink   (input valid, quantity, reading, zero_divisor, output ready);
endinterface

interface esc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/esc_mul64.sv @@
// ----------------------------------------------------------------------------
// esc_mul64: iterative 64x64 multiplier, low 64 bits of the product
// One 32x32 multiplier used in turn on the three partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_mul64
    import esc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mul_req_t    req,
    output logic             done,
    output logic [63:0]      prod
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] m_a;
    logic [31:0] m_b;
    logic [63:0] pp;

    always_comb
    begin
        case (step_reg)
            2'd0:    begin m_a = a_reg[31:0];  m_b = b_reg[31:0];  end
            2'd1:    begin m_a = a_reg[31:0];  m_b = b_reg[63:32]; end
            default: begin m_a = a_reg[63:32]; m_b = b_reg[31:0];  end
        endcase
    end

    assign pp = {32'd0, m_a} * {32'd0, m_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                step_reg <= 2'd0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        else if (busy_reg)
        begin
            if (step_reg == 2'd0)
                acc_reg <= pp;
            else
                acc_reg <= acc_reg + {pp[31:0], 32'd0};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

@@ src/esc_div64.sv @@
// ----------------------------------------------------------------------------
// esc_div64: radix-2 restoring divider, 64-bit signed or unsigned
// One quotient bit per cycle; signed mode truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_div64
    import esc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire div_req_t    req,
    output logic             done,
    output logic [63:0]      quot
);

    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] dvs_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        na;
    logic        nb;
    logic [64:0] trial;
    logic [64:0] diff;

    assign na    = req.sgn & req.a[63];
    assign nb    = req.sgn & req.b[63];
    assign trial = {rem_reg, quo_reg[63]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= 64'd0;
            quo_reg <= na ? (64'd0 - req.a) : req.a;
            dvs_reg <= nb ? (64'd0 - req.b) : req.b;
            neg_reg <= na ^ nb;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                rem_reg <= diff[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? (64'd0 - quo_reg) : quo_reg;

endmodule

`default_nettype wire

@@ src/env_sensor_compensation_core.sv @@
// ----------------------------------------------------------------------------
// env_sensor_compensation_core: fixed-point temperature, pressure, humidity
// Sequencing: each program runs its microcode steps in turn; a pressure sample
// that ends a batch with no zero divisor also runs the average program, and every
// multiply or divide waits on the shared multiplier or the shared divider.
// Throughput: one transaction at a time; the sample channel is ready only idle.
// Reset: asynchronous active-low; coefficients, fine temperature and batch clear.
// ----------------------------------------------------------------------------
`default_nettype none

module env_sensor_compensation_core
    import esc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    esc_sample_if.sink  sample,
    esc_result_if.source result,
    esc_cfg_if.sink     cfg
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    // configuration
    logic [47:0] tcoef_reg;
    logic [63:0] pcoef_lo_reg;
    logic [63:0] pcoef_hi_reg;
    logic [15:0] p9_reg;
    logic [63:0] hcoef_reg;

    // sequencer and working registers
    state_t      state_reg, state_next;
    logic [6:0]  pc_reg, pc_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] y_reg, y_next;
    logic [63:0] z_reg, z_next;
    logic [63:0] w_reg, w_next;
    logic [1:0]  act_reg, act_next;
    logic [19:0] adc_reg, adc_next;
    logic        last_reg, last_next;

    // kept state
    logic [31:0] ft_reg, ft_next;
    logic [63:0] sum_reg, sum_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        dz_reg, dz_next;

    // pending result and output register
    logic [63:0] pend_val_reg, pend_val_next;
    logic        pend_flag_reg, pend_flag_next;
    logic        ov_reg, ov_next;
    logic [1:0]  oq_reg, oq_next;
    logic [32:0] ord_reg, ord_next;
    logic        oz_reg, oz_next;

    uop_t        u;
    logic [63:0] opa;
    logic [63:0] opb;
    logic [63:0] cval;
    logic [63:0] alu;
    logic [63:0] res_raw;
    logic [63:0] res;
    logic        wr;
    logic [15:0] cnt_inc;
    logic        batch_done;
    logic        dz_eff;

    mul_req_t    mul_req;
    div_req_t    div_req;
    logic        mul_done;
    logic        div_done;
    logic [63:0] mul_prod;
    logic [63:0] div_q;

    esc_mul64 u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    esc_div64 u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_q)
    );

    assign u = ucode(pc_reg);

    // coefficient selection, sign or zero extended to the datapath width
    always_comb
    begin
        case (u.c)
            C_T1:    cval = {48'd0, tcoef_reg[15:0]};
            C_T2:    cval = {{48{tcoef_reg[31]}}, tcoef_reg[31:16]};
            C_T3:    cval = {{48{tcoef_reg[47]}}, tcoef_reg[47:32]};
            C_P1:    cval = {48'd0, pcoef_lo_reg[15:0]};
            C_P2:    cval = {{48{pcoef_lo_reg[31]}}, pcoef_lo_reg[31:16]};
            C_P3:    cval = {{48{pcoef_lo_reg[47]}}, pcoef_lo_reg[47:32]};
            C_P4:    cval = {{48{pcoef_lo_reg[63]}}, pcoef_lo_reg[63:48]};
            C_P5:    cval = {{48{pcoef_hi_reg[15]}}, pcoef_hi_reg[15:0]};
            C_P6:    cval = {{48{pcoef_hi_reg[31]}}, pcoef_hi_reg[31:16]};
            C_P7:    cval = {{48{pcoef_hi_reg[47]}}, pcoef_hi_reg[47:32]};
            C_P8:    cval = {{48{pcoef_hi_reg[63]}}, pcoef_hi_reg[63:48]};
            C_P9:    cval = {{48{p9_reg[15]}}, p9_reg};
            C_H1:    cval = {56'd0, hcoef_reg[7:0]};
            C_H2:    cval = {{48{hcoef_reg[23]}}, hcoef_reg[23:8]};
            C_H3:    cval = {56'd0, hcoef_reg[31:24]};
            C_H4:    cval = {52'd0, hcoef_reg[43:32]};
            C_H5:    cval = {52'd0, hcoef_reg[55:44]};
            C_H6:    cval = {{56{hcoef_reg[63]}}, hcoef_reg[63:56]};
            default: cval = 64'd0;
        endcase
    end

    function automatic logic [63:0] pick(input src_t s, input logic [63:0] x,
                                         input logic [63:0] y, input logic [63:0] z,
                                         input logic [63:0] w, input logic [63:0] k,
                                         input logic [63:0] c, input logic [31:0] ft,
                                         input logic [19:0] adc, input logic [63:0] sm,
                                         input logic [15:0] cn);
        logic [63:0] v;
        case (s)
            SRC_X:    v = x;
            SRC_Y:    v = y;
            SRC_Z:    v = z;
            SRC_W:    v = w;
            SRC_K:    v = k;
            SRC_C:    v = c;
            SRC_FT:   v = {{32{ft[31]}}, ft};
            SRC_ADC:  v = {44'd0, adc};
            SRC_HADC: v = {48'd0, adc[15:0]};
            SRC_SUM:  v = sm;
            SRC_CNT:  v = {48'd0, cn};
            default:  v = 64'd0;
        endcase
        return v;
    endfunction

    assign opa = pick(u.a, x_reg, y_reg, z_reg, w_reg, u.k, cval, ft_reg, adc_reg,
                      sum_reg, cnt_reg);
    assign opb = pick(u.b, x_reg, y_reg, z_reg, w_reg, u.k, cval, ft_reg, adc_reg,
                      sum_reg, cnt_reg);

    // combinational ops; multiply and divide go to the shared units
    always_comb
    begin
        case (u.op)
            OP_ADD:   alu = opa + opb;
            OP_SUB:   alu = opa - opb;
            OP_SRA:   alu = 64'($signed(opa) >>> u.sh);
            OP_SHL:   alu = opa << u.sh;
            OP_SHR:   alu = opa >> u.sh;
            OP_CLAMP:
            begin
                if (opa[31])
                    alu = 64'd0;
                else if (opa[31:0] > HUM_CLAMP_MAX)
                    alu = {32'd0, HUM_CLAMP_MAX};
                else
                    alu = opa;
            end
            default:  alu = 64'd0;
        endcase
    end

    // humidity steps wrap at 32 bits; keep them sign-extended
    assign res = u.w32 ? {{32{res_raw[31]}}, res_raw[31:0]} : res_raw;

    assign cnt_inc    = (cnt_reg == CNT_SAT) ? cnt_reg : (cnt_reg + 16'd1);
    assign batch_done = last_reg || (cnt_inc == MAX_BATCH_SAMPLES);

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        w_next         = w_reg;
        act_next       = act_reg;
        adc_next       = adc_reg;
        last_next      = last_reg;
        ft_next        = ft_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        dz_next        = dz_reg;
        pend_val_next  = pend_val_reg;
        pend_flag_next = pend_flag_reg;
        ov_next        = ov_reg;
        oq_next        = oq_reg;
        ord_next       = ord_reg;
        oz_next        = oz_reg;
        mul_req.start  = 1'b0;
        mul_req.a      = opa;
        mul_req.b      = opb;
        div_req.start  = 1'b0;
        div_req.sgn    = (u.op == OP_SDIV);
        div_req.a      = opa;
        div_req.b      = opb;
        wr             = 1'b0;
        res_raw        = alu;
        dz_eff         = dz_reg;

        if (ov_reg && result.ready)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    act_next  = sample.action;
                    adc_next  = sample.raw_reading;
                    last_next = sample.batch_end;
                    case (sample.action)
                        ACT_TEMP:  begin pc_next = PC_TEMP;  state_next = S_EXEC; end
                        ACT_PRESS: begin pc_next = PC_PRESS; state_next = S_EXEC; end
                        ACT_HUM:   begin pc_next = PC_HUM;   state_next = S_EXEC; end
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_EXEC:
            begin
                if (u.op == OP_MUL)
                begin
                    mul_req.start = 1'b1;
                    state_next    = S_MUL;
                end
                else if (u.op == OP_SDIV || u.op == OP_UDIV)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    wr = 1'b1;
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    wr      = 1'b1;
                    res_raw = mul_prod;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    wr      = 1'b1;
                    res_raw = div_q;
                end
            end
            S_OUT:
            begin
                // output register frees up, or is taken this cycle
                if (!ov_reg || result.ready)
                begin
                    ov_next    = 1'b1;
                    oq_next    = act_reg;
                    oz_next    = pend_flag_reg;
                    state_next = S_IDLE;
                    if (act_reg == ACT_TEMP)
                        ord_next = {{17{pend_val_reg[15]}}, pend_val_reg[15:0]};
                    else
                        ord_next = {1'b0, pend_val_reg[31:0]};
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (wr)
        begin
            unique case (u.dst)
                DST_X:   x_next        = res;
                DST_Y:   y_next        = res;
                DST_Z:   z_next        = res;
                DST_W:   w_next        = res;
                DST_FT:  ft_next       = res[31:0];
                DST_SUM: sum_next      = res;
                DST_OUT: pend_val_next = res;
                default: x_next        = res;
            endcase

            pc_next    = pc_reg + 7'd1;
            state_next = S_EXEC;

            case (u.nx)
                NX_OUT:
                begin
                    pend_flag_next = 1'b0;
                    state_next     = S_OUT;
                end
                NX_AVG:
                begin
                    pend_flag_next = 1'b0;
                    sum_next       = 64'd0;
                    cnt_next       = 16'd0;
                    dz_next        = 1'b0;
                    state_next     = S_OUT;
                end
                NX_ZCHK, NX_BATCH:
                begin
                    // a zero divisor skips the rest of the sample
                    if (u.nx == NX_BATCH || res == 64'd0)
                    begin
                        if (u.nx == NX_ZCHK)
                            dz_eff = 1'b1;
                        dz_next  = dz_eff;
                        cnt_next = cnt_inc;
                        if (!batch_done)
                            state_next = S_IDLE;
                        else if (dz_eff)
                        begin
                            pend_val_next  = 64'd0;
                            pend_flag_next = 1'b1;
                            sum_next       = 64'd0;
                            cnt_next       = 16'd0;
                            dz_next        = 1'b0;
                            state_next     = S_OUT;
                        end
                        else
                            pc_next = PC_AVG;
                    end
                end
                default: state_next = S_EXEC;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pc_reg       <= PC_TEMP;
            ft_reg       <= 32'd0;
            sum_reg      <= 64'd0;
            cnt_reg      <= 16'd0;
            dz_reg       <= 1'b0;
            ov_reg       <= 1'b0;
            tcoef_reg    <= 48'd0;
            pcoef_lo_reg <= 64'd0;
            pcoef_hi_reg <= 64'd0;
            p9_reg       <= 16'd0;
            hcoef_reg    <= 64'd0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            ft_reg    <= ft_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            dz_reg    <= dz_next;
            ov_reg    <= ov_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_TEMP:     tcoef_reg    <= cfg.data[47:0];
                    REG_PRESS_LO: pcoef_lo_reg <= cfg.data;
                    REG_PRESS_HI: pcoef_hi_reg <= cfg.data;
                    REG_PRESS_P9: p9_reg       <= cfg.data[15:0];
                    REG_HUM:      hcoef_reg    <= cfg.data;
                    default:      p9_reg       <= p9_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        w_reg         <= w_next;
        act_reg       <= act_next;
        adc_reg       <= adc_next;
        last_reg      <= last_next;
        pend_val_reg  <= pend_val_next;
        pend_flag_reg <= pend_flag_next;
        oq_reg        <= oq_next;
        ord_reg       <= ord_next;
        oz_reg        <= oz_next;
    end

    assign sample.ready        = (state_reg == S_IDLE);
    assign cfg.ready           = 1'b1;
    assign result.valid        = ov_reg;
    assign result.quantity     = oq_reg;
    assign result.reading      = $signed(ord_reg);
    assign result.zero_divisor = oz_reg;

`ifndef SYNTHESIS
    // a valid action starts the sequencer on the next cycle
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready && sample.action != 2'd3)
        |=> (state_reg == S_EXEC))
        else $error("sequencer did not start on accepted sample");

    // shared units only report back while the sequencer waits for them
    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_MUL))
        else $error("multiplier finished outside its wait state");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside its wait state");

    // a batch zero flag always comes with a zero reading
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.zero_divisor) |-> (result.reading == 33'sd0))
        else $error("zero divisor flag with nonzero reading");
`endif

endmodule

`default_nettype wire
